// File: sv/bpa_pkg.sv
// shared types, constants and defaults of the bitmap page allocator
`timescale 1ns / 1ps
package bpa_pkg;

  localparam int ADDR_W = 23;
  localparam int WORD_W = 32;
  localparam int DATA_W = 24;

  localparam int NUM_PAGES_DEF      = 2048;
  localparam int RESERVED_PAGES_DEF = 512;
  localparam int PAGE_SHIFT_DEF     = 12;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MOD,
    ST_FRD,
    ST_FWR,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    logic              alloc_failed;
  } res_t;

endpackage

// File: sv/bpa_bitmap.sv
// usage bitmap memory, one write port and one registered read port
`timescale 1ns / 1ps
module bpa_bitmap #(
  parameter int DEPTH = bpa_pkg::NUM_PAGES_DEF / bpa_pkg::WORD_W,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [bpa_pkg::WORD_W-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [bpa_pkg::WORD_W-1:0] wr_data_i
);

  logic [bpa_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bpa_pkg::WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/bpa_engine.sv
// sequencer with clearing pass, modulo step unit and word scan
`timescale 1ns / 1ps
module bpa_engine #(
  parameter int NUM_PAGES      = bpa_pkg::NUM_PAGES_DEF,
  parameter int RESERVED_PAGES = bpa_pkg::RESERVED_PAGES_DEF,
  parameter int PAGE_SHIFT     = bpa_pkg::PAGE_SHIFT_DEF,
  parameter int WORD_COUNT     = (NUM_PAGES + 31) / 32,
  parameter int WIW            = $clog2(WORD_COUNT)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_cmd_i,
  input  logic [bpa_pkg::ADDR_W-1:0]  in_addr_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output bpa_pkg::res_t               res_o,
  output logic                        rd_en_o,
  output logic [WIW-1:0]              rd_addr_o,
  input  logic [bpa_pkg::WORD_W-1:0]  rd_data_i,
  output logic                        wr_en_o,
  output logic [WIW-1:0]              wr_addr_o,
  output logic [bpa_pkg::WORD_W-1:0]  wr_data_o
);

  localparam int FIRST      = (RESERVED_PAGES > NUM_PAGES) ? NUM_PAGES : RESERVED_PAGES;
  localparam bit ALL_RSV    = (FIRST == NUM_PAGES);
  localparam int FIRST_WORD = FIRST / 32;
  localparam int FIRST_BIT  = FIRST % 32;
  localparam int LAST_BITS  = NUM_PAGES - (WORD_COUNT - 1) * 32;
  localparam int RW         = $clog2(NUM_PAGES) + 1;
  localparam int PW         = bpa_pkg::ADDR_W - PAGE_SHIFT;
  localparam int CW         = 2;
  localparam int MUL_M      = (1 << PW) / NUM_PAGES;

  localparam logic [WIW:0]    FIRST_WORD_L = (WIW+1)'(FIRST_WORD);
  localparam logic [WIW:0]    WC_L         = (WIW+1)'(WORD_COUNT);
  localparam logic [WIW:0]    LAST_WORD_L  = (WIW+1)'(WORD_COUNT - 1);
  localparam logic [WIW:0]    ONE_W        = (WIW+1)'(1);
  localparam logic [RW-1:0]   NP_L         = RW'(NUM_PAGES);
  localparam logic [PW-1:0]   NP_P         = PW'(NUM_PAGES);
  localparam logic [2*PW-1:0] MUL_M_L      = (2*PW)'(MUL_M);
  localparam logic [CW-1:0]   MOD_QUO      = 2'd0;
  localparam logic [CW-1:0]   MOD_SUB      = 2'd1;
  localparam logic [CW-1:0]   MOD_FIX      = 2'd2;
  localparam logic [CW-1:0]   ONE_C        = 2'd1;
  localparam logic [63:0]     LO_FULL      = (64'd1 << FIRST_BIT) - 64'd1;
  localparam logic [63:0]     HI_FULL      = (64'd1 << LAST_BITS) - 64'd1;
  localparam logic [31:0]     LO_MASK      = LO_FULL[31:0];
  localparam logic [31:0]     HI_MASK      = ~HI_FULL[31:0];

  function automatic logic [4:0] lowest_zero(input logic [31:0] w);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!w[i]) begin
        idx = 5'(i);
      end
    end
    return idx;
  endfunction

  bpa_pkg::state_e state_q, state_d;
  logic [WIW:0]    init_q, init_d;
  logic [WIW:0]    scan_q, scan_d;
  logic [WIW:0]    chk_word_q, chk_word_d;
  logic            chk_vld_q, chk_vld_d;
  logic [PW-1:0]   pg_q, pg_d;
  logic [PW-1:0]   quo_q, quo_d;
  logic [RW-1:0]   rem_q, rem_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  bpa_pkg::res_t   res_q, res_d;

  logic [2*PW-1:0] prod;
  logic [PW-1:0]   qnp;
  logic [PW-1:0]   diff;
  logic [31:0]     masked;
  logic            chk_first, chk_last, hit;
  logic [4:0]      zero_idx;
  logic [31:0]     page_full;
  logic [WIW-1:0]  rem_word;
  logic [4:0]      rem_bit;
  logic [31:0]     init_word;

  // quotient estimate by reciprocal multiply, low by at most one
  assign prod      = {{PW{1'b0}}, pg_q} * MUL_M_L;
  assign qnp       = quo_q * NP_P;
  assign diff      = pg_q - qnp;
  assign chk_first = (chk_word_q == FIRST_WORD_L);
  assign chk_last  = (chk_word_q == LAST_WORD_L);
  assign masked    = rd_data_i | (chk_first ? LO_MASK : 32'd0) | (chk_last ? HI_MASK : 32'd0);
  assign hit       = (masked != '1);
  assign zero_idx  = lowest_zero(masked);
  assign page_full = 32'({chk_word_q[WIW-1:0], zero_idx}) << PAGE_SHIFT;
  assign rem_word  = rem_q[WIW+4:5];
  assign rem_bit   = rem_q[4:0];

  always_comb begin
    if (init_q < FIRST_WORD_L) begin
      init_word = '1;
    end else if (init_q == FIRST_WORD_L) begin
      init_word = LO_MASK;
    end else begin
      init_word = '0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpa_pkg::ST_INIT: begin
        if (init_q == LAST_WORD_L) state_d = bpa_pkg::ST_IDLE;
      end
      bpa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == bpa_pkg::CMD_FREE) begin
            state_d = bpa_pkg::ST_MOD;
          end else if (ALL_RSV) begin
            state_d = bpa_pkg::ST_DONE;
          end else begin
            state_d = bpa_pkg::ST_SCAN;
          end
        end
      end
      bpa_pkg::ST_MOD: begin
        if (cnt_q == MOD_FIX) state_d = bpa_pkg::ST_FRD;
      end
      bpa_pkg::ST_FRD: state_d = bpa_pkg::ST_FWR;
      bpa_pkg::ST_FWR: state_d = bpa_pkg::ST_DONE;
      bpa_pkg::ST_SCAN: begin
        if (chk_vld_q && (hit || chk_last)) state_d = bpa_pkg::ST_DONE;
      end
      bpa_pkg::ST_DONE: begin
        if (res_ready_i) state_d = bpa_pkg::ST_IDLE;
      end
      default: state_d = bpa_pkg::ST_INIT;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = scan_q[WIW-1:0];
    wr_en_o     = 1'b0;
    wr_addr_o   = init_q[WIW-1:0];
    wr_data_o   = init_word;
    init_d      = init_q;
    scan_d      = scan_q;
    chk_word_d  = scan_q;
    chk_vld_d   = 1'b0;
    pg_d        = pg_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    case (state_q)
      bpa_pkg::ST_INIT: begin
        wr_en_o = 1'b1;
        init_d  = init_q + ONE_W;
      end
      bpa_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pg_d   = in_addr_i[bpa_pkg::ADDR_W-1:PAGE_SHIFT];
          rem_d  = '0;
          cnt_d  = MOD_QUO;
          scan_d = FIRST_WORD_L;
          res_d.page_address = '0;
          res_d.alloc_failed = (in_cmd_i == bpa_pkg::CMD_ALLOC) && ALL_RSV;
        end
      end
      bpa_pkg::ST_MOD: begin
        cnt_d = cnt_q + ONE_C;
        case (cnt_q)
          MOD_QUO: quo_d = prod[2*PW-1:PW];
          MOD_SUB: rem_d = RW'(diff);
          default: rem_d = (rem_q >= NP_L) ? rem_q - NP_L : rem_q;
        endcase
      end
      bpa_pkg::ST_FRD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = rem_word;
      end
      bpa_pkg::ST_FWR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = rem_word;
        wr_data_o = rd_data_i & ~(32'd1 << rem_bit);
      end
      bpa_pkg::ST_SCAN: begin
        rd_en_o   = (scan_q < WC_L) && !(chk_vld_q && hit);
        scan_d    = scan_q + (WIW+1)'(rd_en_o);
        chk_vld_d = rd_en_o;
        if (chk_vld_q && hit) begin
          wr_en_o   = 1'b1;
          wr_addr_o = chk_word_q[WIW-1:0];
          wr_data_o = rd_data_i | (32'd1 << zero_idx);
          res_d.page_address = page_full[bpa_pkg::ADDR_W-1:0];
          res_d.alloc_failed = 1'b0;
        end else if (chk_vld_q && chk_last) begin
          res_d.page_address = '0;
          res_d.alloc_failed = 1'b1;
        end
      end
      bpa_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bpa_pkg::ST_INIT;
      init_q    <= '0;
      chk_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      init_q    <= init_d;
      chk_vld_q <= chk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    chk_word_q <= chk_word_d;
    pg_q       <= pg_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    res_q      <= res_d;
  end

endmodule

// File: sv/bitmap_page_allocator.sv
// bitmap page allocator: first-fit page frame allocation and release over a usage bitmap
//
// one request per transaction on the s_axis channel: tuser is cmd (0 allocate, 1 free),
// tdata[22:0] is release_address. each request gives exactly one transaction on m_axis:
// tdata[22:0] is page_address, tuser is alloc_failed.
// after reset a clearing pass writes the initial bitmap, one 32-bit word per cycle,
// all ceil(NUM_PAGES/32) words (64 at the defaults), during which s_axis_tready is low.
// requests are handled one at a time by a sequencer around one bitmap memory with one
// read and one write port. allocate: the request is taken, then bitmap words are scanned
// from the first non-reserved word until a free page is found or the last word is checked,
// and the result is loaded into the output. free: the request is taken, the page number
// is reduced modulo NUM_PAGES (reciprocal multiply, multiply and subtract, one correcting
// subtract), one read and one write of the bitmap word, and the result loads the output.
// the result sits in an output register; a new request is accepted while it waits.
// when m_axis_tready stays low, a finished second result is held inside until the
// register drains, and no further request is taken meanwhile.
`timescale 1ns / 1ps
module bitmap_page_allocator #(
  parameter int NUM_PAGES      = bpa_pkg::NUM_PAGES_DEF,
  parameter int RESERVED_PAGES = bpa_pkg::RESERVED_PAGES_DEF,
  parameter int PAGE_SHIFT     = bpa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [bpa_pkg::DATA_W-1:0] s_axis_tdata,  // release_address, pad
  input  logic                       s_axis_tuser,  // cmd
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [bpa_pkg::DATA_W-1:0] m_axis_tdata,  // page_address, pad
  output logic                       m_axis_tuser   // alloc_failed
);

  localparam int WORD_COUNT = (NUM_PAGES + 31) / 32;
  localparam int WIW        = $clog2(WORD_COUNT);

  logic                       res_valid, res_ready;
  bpa_pkg::res_t              res;
  logic                       rd_en, wr_en;
  logic [WIW-1:0]             rd_addr, wr_addr;
  logic [bpa_pkg::WORD_W-1:0] rd_data, wr_data;
  logic                       out_valid_q, out_valid_d;
  bpa_pkg::res_t              out_q, out_d;

  bpa_engine #(
    .NUM_PAGES      (NUM_PAGES),
    .RESERVED_PAGES (RESERVED_PAGES),
    .PAGE_SHIFT     (PAGE_SHIFT),
    .WORD_COUNT     (WORD_COUNT),
    .WIW            (WIW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_addr_i   (s_axis_tdata[bpa_pkg::ADDR_W-1:0]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  bpa_bitmap #(
    .DEPTH (WORD_COUNT),
    .AW    (WIW)
  ) u_bitmap (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(bpa_pkg::DATA_W - bpa_pkg::ADDR_W){1'b0}}, out_q.page_address};
  assign m_axis_tuser  = out_q.alloc_failed;

endmodule
